FILE: sv/dhst_pkg.sv
// shared types, status codes and defaults for the double-hashed symbol table
package dhst_pkg;

    localparam int DHST_CAPACITY  = 256;
    localparam int DHST_KEY_BYTES = 8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] key_chars;
        logic [31:0] new_value;
    } dhst_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [7:0]  slot;
    } dhst_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       clr_write;
        logic       load;
        logic       hash;
        logic       finish;
        logic       rd;
        logic       advance;
        logic       write;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_slot;
        logic       res_val;
    } dhst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic hash_last;
        logic n_last;
        logic used;
        logic key_match;
        logic table_full;
    } dhst_sts_t;

endpackage

FILE: sv/double_hash_symbol_table.sv
// top level of the double-hashed symbol table
//
//  channel | signals                       | direction | word
//  req     | req_valid, req_ready, req     | in        | cmd, key_chars, new_value
//  rsp     | rsp_valid, rsp_ready, rsp     | out       | status, found_value, slot
//
// a word is loaded, its key characters are stepped through in turn for the two
// hashes, then each probe is a read and a compare on the single slot memory
// port; a full-table insert skips probing
// after reset a clearing pass empties every slot of the slot memory,
// req_ready stays low meanwhile
// one word is in work at a time; a finished result waits in the output register
// and the next word may be accepted while it waits
module double_hash_symbol_table #(
    parameter int CAPACITY  = dhst_pkg::DHST_CAPACITY,
    parameter int KEY_BYTES = dhst_pkg::DHST_KEY_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dhst_pkg::dhst_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dhst_pkg::dhst_rsp_t rsp
);
    import dhst_pkg::*;

    dhst_cmd_t cmd;
    dhst_sts_t sts;

    dhst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dhst_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

FILE: sv/dhst_dp.sv
// datapath: key hashing, probe arithmetic, slot memory and result register
module dhst_dp #(
    parameter int CAPACITY  = dhst_pkg::DHST_CAPACITY,
    parameter int KEY_BYTES = dhst_pkg::DHST_KEY_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dhst_pkg::dhst_cmd_t cmd,
    output dhst_pkg::dhst_sts_t sts,
    input  dhst_pkg::dhst_req_t req,
    output dhst_pkg::dhst_rsp_t rsp
);
    import dhst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int W1    = IDX_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int BI_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int MEM_W = 1 + KEY_W + 32;
    localparam logic [W1-1:0] CAP_W1 = W1'(CAPACITY);

    // slot word: used flag, key, value
    logic [MEM_W-1:0] mem [CAPACITY];
    logic [MEM_W-1:0] rd_reg;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] norm_reg;
    logic [31:0]      val_reg;
    logic             is_insert_reg;
    logic             active_reg;
    logic [BI_W-1:0]  cnt_reg;
    logic [IDX_W-1:0] ha_reg;
    logic [IDX_W-1:0] hb_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] n_reg;
    logic [CNT_W-1:0] entry_count_reg;
    dhst_rsp_t        rsp_reg;

    logic [IDX_W-1:0] cmod_tab [256];
    logic [BI_W+2:0]  byte_base;
    logic [7:0]       ch;
    logic             take;
    logic [IDX_W-1:0] cm;
    logic [IDX_W-1:0] ha_next;
    logic [IDX_W-1:0] hb_next;
    logic [IDX_W-1:0] start_next;
    logic [IDX_W-1:0] step_next;
    logic [IDX_W-1:0] idx_next;
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [MEM_W-1:0] mem_wdata;
    logic             rd_used;
    logic [KEY_W-1:0] rd_key;
    logic [31:0]      rd_val;

    // one compare and subtract, values stay below twice the capacity
    function automatic logic [IDX_W-1:0] fold(input logic [W1-1:0] v);
        logic [W1-1:0] r;
        r = (v >= CAP_W1) ? (v - CAP_W1) : v;
        return r[IDX_W-1:0];
    endfunction

    // character modulo capacity
    genvar k;
    for (k = 0; k < 256; k++)
    begin : g_cmod
        localparam logic [IDX_W-1:0] CM_VAL = IDX_W'(k % CAPACITY);
        assign cmod_tab[k] = CM_VAL;
    end

    assign byte_base = {cnt_reg, 3'b000};
    assign ch        = key_reg[byte_base +: 8];
    assign take      = active_reg && (ch != 8'h00);
    assign cm        = cmod_tab[ch];

    // (cap-1)*h + c == c - h and (cap+1)*h + c == h + c, both mod cap
    assign ha_next    = fold({1'b0, cm} + CAP_W1 - {1'b0, ha_reg});
    assign hb_next    = fold({1'b0, hb_reg} + {1'b0, cm});
    assign start_next = fold({ha_reg, 1'b1});
    assign step_next  = fold({hb_reg, 1'b1});
    assign idx_next   = fold({1'b0, idx_reg} + {1'b0, step_reg});

    assign rd_used = rd_reg[MEM_W-1];
    assign rd_key  = rd_reg[32 +: KEY_W];
    assign rd_val  = rd_reg[31:0];

    assign mem_we    = cmd.clr_write || cmd.write;
    assign mem_addr  = cmd.clr_write ? n_reg : idx_reg;
    assign mem_wdata = cmd.clr_write ? '0 : {1'b1, norm_reg, val_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg           <= '0;
            cnt_reg         <= '0;
            active_reg      <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg      <= '0;
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end
            if (cmd.hash)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!take)
                begin
                    active_reg <= 1'b0;
                end
            end
            if (cmd.clr_write || cmd.advance)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.write)
            begin
                entry_count_reg <= entry_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg       <= req.key_chars[KEY_W-1:0];
            val_reg       <= req.new_value;
            is_insert_reg <= (req.cmd == CMD_INSERT);
            norm_reg      <= '0;
            ha_reg        <= '0;
            hb_reg        <= '0;
        end
        if (cmd.hash && take)
        begin
            ha_reg                 <= ha_next;
            hb_reg                 <= hb_next;
            norm_reg[byte_base +: 8] <= ch;
        end
        if (cmd.finish)
        begin
            idx_reg  <= start_next;
            step_reg <= step_next;
        end
        if (cmd.advance)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.res_set)
        begin
            rsp_reg.status      <= cmd.res_status;
            rsp_reg.found_value <= cmd.res_val ? rd_val : 32'h0;
            rsp_reg.slot        <= cmd.res_slot ? 8'(idx_reg) : 8'h00;
        end
    end

    assign sts.is_insert  = is_insert_reg;
    assign sts.hash_last  = (cnt_reg == BI_W'(KEY_BYTES - 1));
    assign sts.n_last     = (n_reg == IDX_W'(CAPACITY - 1));
    assign sts.used       = rd_used;
    assign sts.key_match  = (rd_key == norm_reg);
    assign sts.table_full = (entry_count_reg == CNT_W'(CAPACITY));

    assign rsp = rsp_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> entry_count_reg == $past(entry_count_reg) + 1'b1)
        else $error("entry count did not follow a slot write");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !rd_used && !cmd.clr_write)
        else $error("insert over an occupied slot");

endmodule

FILE: sv/dhst_ctrl.sv
// controller: clearing pass, hash and probe sequencing, response handshake
module dhst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dhst_pkg::dhst_cmd_t cmd,
    input  dhst_pkg::dhst_sts_t sts
);
    import dhst_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] code_reg;
    logic [1:0] code_next;
    logic       slot_en_reg;
    logic       slot_en_next;
    logic       val_en_reg;
    logic       val_en_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        slot_en_next = slot_en_reg;
        val_en_next  = val_en_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.n_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (sts.is_insert && sts.table_full)
                begin
                    code_next    = ST_FULL;
                    slot_en_next = 1'b0;
                    val_en_next  = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                slot_en_next = 1'b0;
                val_en_next  = 1'b0;
                state_next   = S_DONE;
                if (!sts.used)
                begin
                    if (sts.is_insert)
                    begin
                        cmd.write    = 1'b1;
                        code_next    = ST_OK;
                        slot_en_next = 1'b1;
                    end
                    else
                    begin
                        code_next = ST_NOT_FOUND;
                    end
                end
                else if (sts.key_match)
                begin
                    slot_en_next = 1'b1;
                    if (sts.is_insert)
                    begin
                        code_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        code_next   = ST_OK;
                        val_en_next = 1'b1;
                    end
                end
                else if (sts.n_last)
                begin
                    code_next = sts.is_insert ? ST_FULL : ST_NOT_FOUND;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = code_reg;
                    cmd.res_slot   = slot_en_reg;
                    cmd.res_val    = val_en_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.res_set)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= ST_OK;
            slot_en_reg   <= 1'b0;
            val_en_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            slot_en_reg   <= slot_en_next;
            val_en_reg    <= val_en_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_set |=> rsp_valid_reg)
        else $error("result loaded but no word offered");

    a_rd_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> state_reg == S_CHECK)
        else $error("slot read not followed by check");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_HASH)
        else $error("accepted word not hashed");

endmodule
